@@ src/five_tap_spatiotemporal_gradient_assert.svh @@
// ----------------------------------------------------------------------------
// Gradient block assertion macros
// Short forms for the concurrent checks of the gradient block.
// ----------------------------------------------------------------------------
`ifndef FIVE_TAP_SPATIOTEMPORAL_GRADIENT_ASSERT_SVH
`define FIVE_TAP_SPATIOTEMPORAL_GRADIENT_ASSERT_SVH

// A property that holds at every clock edge outside reset.
`define FTSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define FTSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ftsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient block package
// Types, constants and stencil helpers shared by the gradient block.
// ----------------------------------------------------------------------------
package ftsg_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned GRAD_W   = 23;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned FW_W     = 12;
  localparam int unsigned FH_W     = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned PROW_W   = 17;
  localparam int unsigned TAP_W    = 3;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic [TAP_W-1:0] TAP_M2 = 3'd0;
  localparam logic [TAP_W-1:0] TAP_M1 = 3'd1;
  localparam logic [TAP_W-1:0] TAP_C  = 3'd2;
  localparam logic [TAP_W-1:0] TAP_P1 = 3'd3;
  localparam logic [TAP_W-1:0] TAP_P2 = 3'd4;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } command_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] src;
    logic [SAMPLE_W-1:0] tgt;
  } pair_t;

  typedef pair_t [3:0] col_word_t;

  typedef struct packed {
    logic [TAP_W-1:0] m2;
    logic [TAP_W-1:0] m1;
    logic [TAP_W-1:0] p1;
    logic [TAP_W-1:0] p2;
  } taps_t;

  typedef struct packed {
    logic single;
    logic lo0;
    logic lo1;
    logic hi0;
    logic hi1;
  } bound_t;

  typedef struct packed {
    logic  emit;
    logic  fend;
    taps_t vtap;
    taps_t htap;
  } stage_t;

  // Mirrored border with edge repeat, given as tap positions in a five-wide window.
  function automatic taps_t make_taps(bound_t b);
    taps_t t;
    t.m2 = TAP_M2;
    t.m1 = TAP_M1;
    t.p1 = TAP_P1;
    t.p2 = TAP_P2;
    if (b.single) begin
      t.m2 = TAP_C;
      t.m1 = TAP_C;
      t.p1 = TAP_C;
      t.p2 = TAP_C;
    end else begin
      if (b.lo0) begin
        t.m2 = TAP_P1;
        t.m1 = TAP_C;
      end else if (b.lo1) begin
        t.m2 = TAP_M1;
      end
      if (b.hi0) begin
        t.p1 = TAP_C;
        t.p2 = TAP_M1;
      end else if (b.hi1) begin
        t.p2 = TAP_P1;
      end
    end
    return t;
  endfunction

  function automatic logic [SUM_W-1:0] pair_sum(pair_t p);
    return SUM_W'(p.src) + SUM_W'(p.tgt);
  endfunction

  function automatic logic signed [GRAD_W-1:0] stencil(logic [SUM_W-1:0] a,
                                                       logic [SUM_W-1:0] b,
                                                       logic [SUM_W-1:0] c,
                                                       logic [SUM_W-1:0] d);
    logic signed [GRAD_W-1:0] ea, eb, ec, ed;
    ea = $signed(GRAD_W'(a));
    eb = $signed(GRAD_W'(b));
    ec = $signed(GRAD_W'(c));
    ed = $signed(GRAD_W'(d));
    return ea - (eb <<< 3) + (ec <<< 3) - ed;
  endfunction

endpackage

@@ src/ftsg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ftsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/five_tap_spatiotemporal_gradient.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-tap spatiotemporal gradient
// Streams source and target pixel pairs and gives x, y and temporal gradients.
// ----------------------------------------------------------------------------
// Pixel words arrive on the input channel in raster order with command pixel;
// after the last pixel of a frame, drain words fetch the pending results one at
// a time. Results leave on the output channel, each word holding both spatial
// gradients scaled by 24, the temporal difference and a frame end flag. The
// result for a position follows the pixel that completes its stencil, two rows
// and two pixels later, via stages one and two and the output register. One
// word is taken every cycle unless stalled. A column memory holding the four
// previous rows of every column is read and written back once per word, which
// sets the rate; a write and a read of the same column in adjacent words are
// forwarded. If a frame is smaller than its result lag, the first drain word
// waits while the block steps through missing positions at the same rate.
// Reset sets the frame to 640 by 480 and starts a new frame. The configuration
// channel is always ready; a write starts a new frame. While the receiver
// stalls, the output word holds and the input is stalled in the same cycle.
// ----------------------------------------------------------------------------
`include "five_tap_spatiotemporal_gradient_assert.svh"

module five_tap_spatiotemporal_gradient #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     command_i,
  input  logic [ftsg_pkg::SAMPLE_W-1:0]            source_sample_i,
  input  logic [ftsg_pkg::SAMPLE_W-1:0]            target_sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [ftsg_pkg::GRAD_W-1:0]       grad_x_scaled_o,
  output logic signed [ftsg_pkg::GRAD_W-1:0]       grad_y_scaled_o,
  output logic signed [ftsg_pkg::DIFF_W-1:0]       temporal_diff_o,
  output logic                                     frame_end_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic                                     cfg_index_i,
  input  logic [ftsg_pkg::CFG_W-1:0]               cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);

  logic [ftsg_pkg::FW_W-1:0] frame_width_q;
  logic [ftsg_pkg::FH_W-1:0] frame_height_q;
  logic [WID_W-1:0]          w_eff, w_last;
  logic [ftsg_pkg::FH_W-1:0] h_eff;
  logic                      cfg_we;

  logic [COL_W-1:0]            p_col_q, p_col_d, o_col_q, o_col_d;
  logic [ftsg_pkg::PROW_W-1:0] p_row_q, p_row_d, h_ext;
  logic [ftsg_pkg::ROW_W-1:0]  o_row_q, o_row_d;

  logic adv, done, lag_ok, fill, in_take;
  logic issue_real, issue_drain, issue, issue_emit, issue_fend, o_last;
  logic cnt_clear;
  ftsg_pkg::bound_t vb, hb;
  ftsg_pkg::stage_t issue_stage;

  logic                  s1_valid_q;
  ftsg_pkg::stage_t      s1_q;
  ftsg_pkg::pair_t       s1_pix_q;
  logic [COL_W-1:0]      s1_col_q;
  ftsg_pkg::col_word_t   ram_rdata, old_word, new_word;
  logic                  fwd_valid_q;
  logic [COL_W-1:0]      fwd_addr_q;
  ftsg_pkg::col_word_t   fwd_word_q;
  ftsg_pkg::pair_t       vec [5];
  logic signed [ftsg_pkg::GRAD_W-1:0] v_grad;

  logic                  s2_valid_q;
  ftsg_pkg::stage_t      s2_q;
  ftsg_pkg::pair_t       win_q [5];
  logic signed [ftsg_pkg::GRAD_W-1:0] vline_q [3];
  logic signed [ftsg_pkg::GRAD_W-1:0] h_grad;
  logic signed [ftsg_pkg::DIFF_W-1:0] t_diff;

  logic                               out_valid_q;
  logic signed [ftsg_pkg::GRAD_W-1:0] gx_q, gy_q;
  logic signed [ftsg_pkg::DIFF_W-1:0] td_q;
  logic                               fend_q;

  // Configuration.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ftsg_pkg::FRAME_WIDTH_RST;
      frame_height_q <= ftsg_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        ftsg_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[ftsg_pkg::FW_W-1:0];
        ftsg_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(frame_width_q);
    end
  end

  assign h_eff  = (frame_height_q == '0) ? ftsg_pkg::FH_W'(1) : frame_height_q;
  assign w_last = w_eff - WID_W'(1);
  assign h_ext  = ftsg_pkg::PROW_W'(h_eff);

  // Issue control.
  assign adv    = !out_valid_q || !out_stall_i;
  assign done   = p_row_q >= h_ext;
  assign lag_ok = (p_row_q > ftsg_pkg::PROW_W'(3))
               || (p_row_q == ftsg_pkg::PROW_W'(3) && w_eff != WID_W'(1))
               || (p_row_q == ftsg_pkg::PROW_W'(2) && WID_W'(p_col_q) >= WID_W'(2));
  assign fill   = done && !lag_ok;

  assign in_stall_o  = !adv || fill;
  assign in_take     = in_valid_i && !in_stall_o;
  assign issue_real  = in_take && command_i == ftsg_pkg::CMD_PIXEL && !done;
  assign issue_drain = in_take && command_i == ftsg_pkg::CMD_DRAIN && done;
  assign issue       = issue_real || issue_drain || (adv && fill);
  assign issue_emit  = (issue_real && lag_ok) || issue_drain;
  assign o_last      = o_row_q == h_eff - ftsg_pkg::FH_W'(1) && WID_W'(o_col_q) == w_last;
  assign issue_fend  = issue_emit && o_last;

  always_comb begin
    vb.single = h_eff == ftsg_pkg::FH_W'(1);
    vb.lo0    = p_row_q == ftsg_pkg::PROW_W'(2);
    vb.lo1    = p_row_q == ftsg_pkg::PROW_W'(3);
    vb.hi0    = p_row_q == h_ext + ftsg_pkg::PROW_W'(1);
    vb.hi1    = p_row_q == h_ext;
    hb.single = w_eff == WID_W'(1);
    hb.lo0    = o_col_q == '0;
    hb.lo1    = o_col_q == COL_W'(1);
    hb.hi0    = WID_W'(o_col_q) == w_last;
    hb.hi1    = WID_W'(o_col_q) == w_eff - WID_W'(2);
    issue_stage.emit = issue_emit;
    issue_stage.fend = issue_fend;
    issue_stage.vtap = ftsg_pkg::make_taps(vb);
    issue_stage.htap = ftsg_pkg::make_taps(hb);
  end

  always_comb begin
    p_col_d = p_col_q;
    p_row_d = p_row_q;
    o_col_d = o_col_q;
    o_row_d = o_row_q;
    if (cfg_we || issue_fend) begin
      p_col_d = '0;
      p_row_d = '0;
      o_col_d = '0;
      o_row_d = '0;
    end else if (issue) begin
      if (WID_W'(p_col_q) == w_last) begin
        p_col_d = '0;
        p_row_d = p_row_q + ftsg_pkg::PROW_W'(1);
      end else begin
        p_col_d = p_col_q + COL_W'(1);
      end
      if (issue_emit) begin
        if (WID_W'(o_col_q) == w_last) begin
          o_col_d = '0;
          o_row_d = o_row_q + ftsg_pkg::ROW_W'(1);
        end else begin
          o_col_d = o_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_col_q <= '0;
      p_row_q <= '0;
      o_col_q <= '0;
      o_row_q <= '0;
    end else begin
      p_col_q <= p_col_d;
      p_row_q <= p_row_d;
      o_col_q <= o_col_d;
      o_row_q <= o_row_d;
    end
  end

  // Stage one: column read, shift in the new row and write back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= issue_stage;
      s1_pix_q   <= {source_sample_i, target_sample_i};
      s1_col_q   <= p_col_q;
      fwd_addr_q <= s1_col_q;
      fwd_word_q <= new_word;
    end
  end

  ftsg_ram #(
    .WIDTH ($bits(ftsg_pkg::col_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && adv),
    .waddr_i (s1_col_q),
    .wdata_i (new_word),
    .re_i    (adv),
    .raddr_i (p_col_q),
    .rdata_o (ram_rdata)
  );

  assign old_word = (fwd_valid_q && fwd_addr_q == s1_col_q) ? fwd_word_q : ram_rdata;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vec[k] = old_word[k];
    end
    vec[4] = s1_pix_q;
    for (int k = 0; k < 4; k++) begin
      new_word[k] = vec[k+1];
    end
    v_grad = ftsg_pkg::stencil(ftsg_pkg::pair_sum(vec[s1_q.vtap.m2]),
                               ftsg_pkg::pair_sum(vec[s1_q.vtap.m1]),
                               ftsg_pkg::pair_sum(vec[s1_q.vtap.p1]),
                               ftsg_pkg::pair_sum(vec[s1_q.vtap.p2]));
  end

  // Stage two: centre row window and vertical gradient delay line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s1_q;
      if (s1_valid_q) begin
        for (int k = 0; k < 4; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[4]   <= vec[2];
        vline_q[2] <= vline_q[1];
        vline_q[1] <= vline_q[0];
        vline_q[0] <= v_grad;
      end
    end
  end

  always_comb begin
    h_grad = ftsg_pkg::stencil(ftsg_pkg::pair_sum(win_q[s2_q.htap.m2]),
                               ftsg_pkg::pair_sum(win_q[s2_q.htap.m1]),
                               ftsg_pkg::pair_sum(win_q[s2_q.htap.p1]),
                               ftsg_pkg::pair_sum(win_q[s2_q.htap.p2]));
    t_diff = $signed(ftsg_pkg::DIFF_W'(win_q[2].src) - ftsg_pkg::DIFF_W'(win_q[2].tgt));
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q && s2_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_q.emit) begin
      gx_q   <= h_grad;
      gy_q   <= vline_q[2];
      td_q   <= t_diff;
      fend_q <= s2_q.fend;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign grad_x_scaled_o = gx_q;
  assign grad_y_scaled_o = gy_q;
  assign temporal_diff_o = td_q;
  assign frame_end_o     = fend_q;

  assign cnt_clear = p_col_q == '0 && p_row_q == '0 && o_col_q == '0 && o_row_q == '0;

  `FTSG_ASSERT(fill_stalls_input_a, !fill || in_stall_o, "Input taken while filling")
  `FTSG_ASSERT(out_row_in_frame_a, o_row_q < h_eff, "Output row beyond frame height")
  `FTSG_ASSERT_NEXT(frame_end_restart_a, issue_fend, cnt_clear, "Counters not cleared")
  `FTSG_ASSERT_NEXT(emit_reaches_out_a, adv && s2_valid_q && s2_q.emit, out_valid_q, "Result lost")

endmodule
